@@ design/assert_macros.svh @@
// Assertion helpers, clocked on clk and quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge once reset is released.
`define ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked only when reset was already released at the previous edge.
`define ASSERT_AFTER_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) $past(rst_n) |-> (prop)) \
    else $error(msg);

`endif

@@ design/jjrc_pkg.sv @@
package jjrc_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int TIME_WIDTH  = 32;

  localparam int ANG_W  = 12;
  localparam int LEG_W  = 12;
  localparam int TS_W   = 32;
  localparam int DUR_W  = 16;
  localparam int OCNT_W = 16;
  localparam int CIDX_W = 3;
  localparam int CDAT_W = 16;

  typedef enum logic [1:0] {
    PH_CLOSED  = 2'd0,
    PH_OPENING = 2'd1,
    PH_OPENED  = 2'd2,
    PH_CLOSING = 2'd3
  } phase_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_ARM_CLOSED  = 3'd0,
    REG_ARM_OPENED  = 3'd1,
    REG_ARM_MARGIN  = 3'd2,
    REG_LEG_CLOSED  = 3'd3,
    REG_LEG_OPENED  = 3'd4,
    REG_LEG_START   = 3'd5,
    REG_LEG_DROP    = 3'd6,
    REG_MIN_REP     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [ANG_W-1:0] arm_closed_thresh;
    logic [ANG_W-1:0] arm_opened_thresh;
    logic [ANG_W-1:0] arm_margin;
    logic [LEG_W-1:0] leg_closed_ratio;
    logic [LEG_W-1:0] leg_opened_ratio;
    logic [LEG_W-1:0] leg_start_margin;
    logic [LEG_W-1:0] leg_drop_margin;
    logic [DUR_W-1:0] min_rep_ms;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    arm_closed_thresh: 12'd640,
    arm_opened_thresh: 12'd2080,
    arm_margin:        12'd240,
    leg_closed_ratio:  12'd282,
    leg_opened_ratio:  12'd397,
    leg_start_margin:  12'd38,
    leg_drop_margin:   12'd51,
    min_rep_ms:        16'd350
  };

  typedef struct packed {
    logic             pose_valid;
    logic [ANG_W-1:0] arm_angle_left;
    logic [ANG_W-1:0] arm_angle_right;
    logic [LEG_W-1:0] leg_spread;
    logic [TS_W-1:0]  frame_ms;
  } frame_t;

  typedef struct packed {
    logic              rep_done;
    logic              rep_was_valid;
    logic [1:0]        phase;
    logic [OCNT_W-1:0] total_count;
    logic [OCNT_W-1:0] valid_count;
  } result_t;

  typedef struct packed {
    phase_t                 phase;
    logic [COUNT_WIDTH-1:0] total_cnt;
    logic [COUNT_WIDTH-1:0] valid_cnt;
    logic [ANG_W-1:0]       peak_arm;
    logic [LEG_W-1:0]       peak_leg;
    logic [TIME_WIDTH-1:0]  start_time;
  } state_t;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

endpackage

@@ design/jjrc_in_if.sv @@
interface jjrc_in_if import jjrc_pkg::*;;
  logic             valid;
  logic             ready;
  logic             pose_valid;
  logic [ANG_W-1:0] arm_angle_left;
  logic [ANG_W-1:0] arm_angle_right;
  logic [LEG_W-1:0] leg_spread;
  logic [TS_W-1:0]  frame_ms;

  modport source (output valid, pose_valid, arm_angle_left, arm_angle_right, leg_spread,
                  frame_ms, input ready);
  modport sink (input valid, pose_valid, arm_angle_left, arm_angle_right, leg_spread,
                frame_ms, output ready);
endinterface

@@ design/jjrc_out_if.sv @@
interface jjrc_out_if import jjrc_pkg::*;;
  logic              valid;
  logic              ready;
  logic              rep_done;
  logic              rep_was_valid;
  logic [1:0]        phase;
  logic [OCNT_W-1:0] total_count;
  logic [OCNT_W-1:0] valid_count;

  modport source (output valid, rep_done, rep_was_valid, phase, total_count, valid_count,
                  input ready);
  modport sink (input valid, rep_done, rep_was_valid, phase, total_count, valid_count,
                output ready);
endinterface

@@ design/jjrc_cfg_if.sv @@
interface jjrc_cfg_if import jjrc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [CDAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ design/jjrc_step.sv @@
module jjrc_step import jjrc_pkg::*; (
  input  cfg_t    cfg,
  input  state_t  st,
  input  frame_t  frame,
  output state_t  st_nxt,
  output result_t res
);

  logic [ANG_W:0]        arm_sum;
  logic [ANG_W-1:0]      avg;
  logic [LEG_W-1:0]      leg;
  logic [TIME_WIDTH-1:0] ts;
  logic [TIME_WIDTH-1:0] dur;
  logic [ANG_W-1:0]      pk_arm_upd;
  logic [LEG_W-1:0]      pk_leg_upd;
  logic                  start_hit;
  logic                  full_open;
  logic                  turnaround;
  logic                  drop;
  logic                  closed_pose;
  logic                  long_enough;
  phase_t                phase_nxt;
  logic                  finish;
  logic                  done;
  logic                  good;

  always_comb begin
    arm_sum    = {1'b0, frame.arm_angle_left} + {1'b0, frame.arm_angle_right};
    avg        = arm_sum[ANG_W:1];
    leg        = frame.leg_spread;
    ts         = frame.frame_ms[TIME_WIDTH-1:0];
    dur        = ts - st.start_time;
    pk_arm_upd = (avg > st.peak_arm) ? avg : st.peak_arm;
    pk_leg_upd = (leg > st.peak_leg) ? leg : st.peak_leg;
    start_hit  = ({1'b0, avg} > {1'b0, cfg.arm_closed_thresh} + {1'b0, cfg.arm_margin}) ||
                 ({1'b0, leg} > {1'b0, cfg.leg_closed_ratio} + {1'b0, cfg.leg_start_margin});
    full_open  = (avg >= cfg.arm_opened_thresh) && (leg >= cfg.leg_opened_ratio);
    turnaround = ({1'b0, avg} + {1'b0, cfg.arm_margin}) < {1'b0, pk_arm_upd};
    drop       = (({1'b0, avg} + {1'b0, cfg.arm_margin}) < {1'b0, cfg.arm_opened_thresh}) ||
                 (({1'b0, leg} + {1'b0, cfg.leg_drop_margin}) < {1'b0, cfg.leg_opened_ratio});
    closed_pose = (avg < cfg.arm_closed_thresh) && (leg < cfg.leg_closed_ratio);
    long_enough = dur >= TIME_WIDTH'(cfg.min_rep_ms);
  end

  // next phase
  always_comb begin
    phase_nxt = st.phase;
    finish    = 1'b0;
    if (frame.pose_valid) begin
      unique case (st.phase)
        PH_CLOSED: begin
          if (start_hit) phase_nxt = PH_OPENING;
        end
        PH_OPENING: begin
          priority if (full_open) phase_nxt = PH_OPENED;
          else if (turnaround)    phase_nxt = PH_CLOSING;
        end
        PH_OPENED: begin
          if (drop) begin
            phase_nxt = PH_CLOSING;
            if (closed_pose) begin
              phase_nxt = PH_CLOSED;
              finish    = 1'b1;
            end
          end
        end
        PH_CLOSING: begin
          if (closed_pose) begin
            phase_nxt = PH_CLOSED;
            finish    = 1'b1;
          end
        end
        default: phase_nxt = st.phase;
      endcase
    end
  end

  // peaks, counters and result
  always_comb begin
    st_nxt       = st;
    st_nxt.phase = phase_nxt;
    done         = 1'b0;
    good         = 1'b0;
    if (frame.pose_valid) begin
      unique case (st.phase)
        PH_CLOSED: begin
          if (start_hit) begin
            st_nxt.start_time = ts;
            st_nxt.peak_arm   = avg;
            st_nxt.peak_leg   = leg;
          end
        end
        PH_OPENING, PH_OPENED: begin
          st_nxt.peak_arm = pk_arm_upd;
          st_nxt.peak_leg = pk_leg_upd;
        end
        default: ;
      endcase
      if (finish) begin
        if (long_enough) begin
          done = 1'b1;
          if (st.total_cnt != COUNT_MAX) st_nxt.total_cnt = st.total_cnt + 1'b1;
          if ((st_nxt.peak_arm >= cfg.arm_opened_thresh) &&
              (st_nxt.peak_leg >= cfg.leg_opened_ratio)) begin
            good = 1'b1;
            if (st.valid_cnt != COUNT_MAX) st_nxt.valid_cnt = st.valid_cnt + 1'b1;
          end
        end
        st_nxt.peak_arm = '0;
        st_nxt.peak_leg = '0;
      end
    end
    res.rep_done      = done;
    res.rep_was_valid = good;
    res.phase         = phase_nxt;
    res.total_count   = OCNT_W'(st_nxt.total_cnt);
    res.valid_count   = OCNT_W'(st_nxt.valid_cnt);
  end

endmodule

@@ design/jumping_jack_rep_counter.sv @@
// Jumping-jack repetition counter.
// in_ch: one pose frame per item (valid/ready). Frames with pose_valid low
//   pass through without touching the state but still return a result.
// out_ch: exactly one result per frame, in order: rep_done, rep_was_valid,
//   phase after the frame, and the saturating total and valid counts.
// cfg_ch: register writes by index (0..7), ready whenever reset is released;
//   write only while the block holds no frame whose result is undelivered.
// Pipeline: one input register holds an accepted frame, and one result
//   register holds its result and drives out_ch.
// Throughput: one frame per cycle unless out_ch stalls; the phase/peak/counter
//   update is one pass of compare logic between the input and result registers.
// Stall: when out_ch is held, the result register keeps its item, the input
//   register fills, and in_ch.ready drops until the result is taken.
// Reset (rst_n low, synchronous): phase closed, counters and peaks zero,
//   registers back to defaults, both pipeline stages empty, in_ch.ready and
//   cfg_ch.ready low.
module jumping_jack_rep_counter import jjrc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  jjrc_in_if.sink    in_ch,
  jjrc_out_if.source out_ch,
  jjrc_cfg_if.sink   cfg_ch
);

`include "assert_macros.svh"

  cfg_t    cfg_r;
  state_t  st_r;
  state_t  st_nxt;
  frame_t  frm_r;
  logic    frm_v_r;
  result_t res_r;
  result_t res_nxt;
  logic    res_v_r;
  logic    out_free;
  logic    advance;

  assign out_free    = !res_v_r || out_ch.ready;
  assign advance     = frm_v_r && out_free;
  assign in_ch.ready = rst_n && (!frm_v_r || out_free);
  assign cfg_ch.ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_ch.valid) begin
      unique case (reg_idx_t'(cfg_ch.index))
        REG_ARM_CLOSED: cfg_r.arm_closed_thresh <= cfg_ch.data[ANG_W-1:0];
        REG_ARM_OPENED: cfg_r.arm_opened_thresh <= cfg_ch.data[ANG_W-1:0];
        REG_ARM_MARGIN: cfg_r.arm_margin        <= cfg_ch.data[ANG_W-1:0];
        REG_LEG_CLOSED: cfg_r.leg_closed_ratio  <= cfg_ch.data[LEG_W-1:0];
        REG_LEG_OPENED: cfg_r.leg_opened_ratio  <= cfg_ch.data[LEG_W-1:0];
        REG_LEG_START:  cfg_r.leg_start_margin  <= cfg_ch.data[LEG_W-1:0];
        REG_LEG_DROP:   cfg_r.leg_drop_margin   <= cfg_ch.data[LEG_W-1:0];
        REG_MIN_REP:    cfg_r.min_rep_ms        <= cfg_ch.data[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      frm_r.pose_valid      <= in_ch.pose_valid;
      frm_r.arm_angle_left  <= in_ch.arm_angle_left;
      frm_r.arm_angle_right <= in_ch.arm_angle_right;
      frm_r.leg_spread      <= in_ch.leg_spread;
      frm_r.frame_ms        <= in_ch.frame_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frm_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      frm_v_r <= in_ch.valid;
    end
  end

  jjrc_step u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .frame  (frm_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{phase: PH_CLOSED, default: '0};
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
    end else if (out_free) begin
      res_v_r <= frm_v_r;
    end
  end

  assign out_ch.valid         = res_v_r;
  assign out_ch.rep_done      = res_r.rep_done;
  assign out_ch.rep_was_valid = res_r.rep_was_valid;
  assign out_ch.phase         = res_r.phase;
  assign out_ch.total_count   = res_r.total_count;
  assign out_ch.valid_count   = res_r.valid_count;

  `ASSERT_RUN(a_good_needs_done, !res_v_r || !res_r.rep_was_valid || res_r.rep_done,
              "valid rep without done")
  `ASSERT_RUN(a_valid_le_total, st_r.valid_cnt <= st_r.total_cnt,
              "valid count exceeds total")
  `ASSERT_RUN(a_closed_no_peak,
              st_r.phase != PH_CLOSED || (st_r.peak_arm == '0 && st_r.peak_leg == '0),
              "peaks held while closed")
  `ASSERT_AFTER_RST(a_total_mono, st_r.total_cnt >= $past(st_r.total_cnt),
                    "total count went down")
  `ASSERT_RUN(a_frame_held, (frm_v_r && !out_free) |=> frm_v_r,
              "frame dropped under stall")

endmodule
